[hw/rtl/wsm_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsm_pkg
// Shared types and constants of the word sequence matcher.
// ----------------------------------------------------------------------------
package wsm_pkg;

  localparam int unsigned CMD_W       = 2;
  localparam int unsigned SLOT_W      = 4;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned LEN_W       = 5;
  localparam int unsigned CNT_W       = 32;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 40;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD = 2'd0,
    CMD_WORD = 2'd1,
    CMD_EOS  = 2'd2
  } wsm_cmd_e;

  // Per-beat control broadcast to every cell
  typedef struct packed {
    logic load;
    logic step;
    logic clear;
  } wsm_ctrl_t;

  typedef struct packed {
    logic [CNT_W-1:0] sentence_number;
    logic             found;
  } wsm_result_t;

endpackage

[hw/rtl/wsm_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsm_cell
// One query position: holds its query word and a flag telling whether the
// newest words end in the query prefix up to and including this position.
// ----------------------------------------------------------------------------
module wsm_cell import wsm_pkg::*; #(
  parameter int unsigned IDX  = 0,
  parameter int unsigned ID_W = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  wsm_ctrl_t        ctrl_i,
  input  logic [SLOT_W-1:0] slot_i,
  input  logic [ID_W-1:0]  word_i,
  input  logic             match_prev_i,
  output logic             match_q_o,
  output logic             match_d_o
);

  logic [ID_W-1:0] query_q;
  logic            match_q;
  logic            match_d;
  logic            slot_sel;

  assign slot_sel = (IDX < (1 << SLOT_W)) && (slot_i == SLOT_W'(IDX));

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load && slot_sel) begin
      query_q <= word_i;
    end
  end

  // Extend the neighbor's prefix match by one word
  always_comb begin
    match_d = match_q;
    if (ctrl_i.clear) begin
      match_d = 1'b0;
    end else if (ctrl_i.step) begin
      match_d = match_prev_i && (word_i == query_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else begin
      match_q <= match_d;
    end
  end

  assign match_q_o = match_q;
  assign match_d_o = match_d;

endmodule

[hw/rtl/wsm_out_buf.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsm_out_buf
// Two-entry result buffer between the matcher and the output stream.
// ----------------------------------------------------------------------------
module wsm_out_buf import wsm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  wsm_result_t data_i,
  output logic        ready_o,
  output logic        valid_o,
  output wsm_result_t data_o,
  input  logic        ready_i
);

  logic [1:0]  cnt_q, cnt_d;
  wsm_result_t head_q, tail_q;
  logic        pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != 2'd0);
  assign ready_o = (cnt_q != 2'd2);
  assign data_o  = head_q;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_q == 2'd2 && pop) begin
      head_q <= tail_q;
    end else if (push_i && (cnt_q == 2'd0 || (cnt_q == 2'd1 && pop))) begin
      head_q <= data_i;
    end
    if (push_i && cnt_q == 2'd1 && !pop) begin
      tail_q <= data_i;
    end
  end

endmodule

[hw/rtl/word_sequence_matcher.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// word_sequence_matcher
// Finds a query run of word ids inside a stream of sentence words.
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel writes query_length (0 means the empty query, which matches
//   every sentence). Write it only while the block is idle.
//   s_axis beats carry a command in tuser: load a query word into a slot
//   (also restarts sentence numbering and drops any partial sentence), a
//   sentence word, or end of sentence. Unused command codes are dropped.
//   m_axis returns one beat per end of sentence: found flag and the sentence
//   number counted from the last query load.
// Throughput: one input beat per cycle while s_axis_tready_o is high. Each
//   query position is a cell that compares the incoming word with its query
//   word and extends the prefix match of its neighbor, so a word is fully
//   processed in the cycle it is accepted.
// Output: the result of an end-of-sentence beat is registered in the result
//   buffer and appears on m_axis once the results ahead of it are taken.
// Stall: a two-entry result buffer holds results; s_axis_tready_o drops only
//   while both entries wait on the receiver.
// Reset: clears match flags, hit flag, sentence counter, query_length and the
//   result buffer. Query words hold garbage until loaded.
// ----------------------------------------------------------------------------
module word_sequence_matcher import wsm_pkg::*; #(
  parameter int unsigned MAX_QUERY = 16,
  parameter int unsigned ID_BITS   = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration: query_length
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [LEN_W-1:0]       cfg_data_i,
  // input stream
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,  // [3:0] query_slot, [35:4] word_id
  input  logic [CMD_W-1:0]       s_axis_tuser_i,  // [1:0] cmd
  // result stream
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o   // [0] found, [32:1] sentence_number
);

  localparam int unsigned IdW  = (ID_BITS < WORD_W) ? ID_BITS : WORD_W;
  localparam int unsigned LenW = $clog2(MAX_QUERY + 1);
  localparam int unsigned CmpW = (LenW > LEN_W) ? LenW : LEN_W;
  localparam int unsigned IdxW = (MAX_QUERY > 1) ? $clog2(MAX_QUERY) : 1;

  logic [LEN_W-1:0]  query_length_q;
  logic [CmpW-1:0]   len_ext, len_eff;
  logic [IdxW-1:0]   tap_idx;
  logic              s_accept;
  logic [CMD_W-1:0]  cmd;
  logic [SLOT_W-1:0] slot;
  logic [IdW-1:0]    word;
  wsm_ctrl_t         ctrl;
  logic              hit_q, hit_d;
  logic [CNT_W-1:0]  sentence_cnt_q, sentence_cnt_d;
  logic              push;
  wsm_result_t       result, head;
  logic              match_q [MAX_QUERY];
  logic              match_d [MAX_QUERY];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      query_length_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      query_length_q <= cfg_data_i;
    end
  end

  assign len_ext = CmpW'(query_length_q);
  assign len_eff = (len_ext > CmpW'(MAX_QUERY)) ? CmpW'(MAX_QUERY) : len_ext;
  assign tap_idx = IdxW'(len_eff - CmpW'(1));

  assign s_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign cmd      = s_axis_tuser_i;
  assign slot     = s_axis_tdata_i[SLOT_W-1:0];
  assign word     = s_axis_tdata_i[SLOT_W +: IdW];

  // Decode the command into the cell broadcast
  always_comb begin
    ctrl = '0;
    push = 1'b0;
    if (s_accept) begin
      unique case (cmd)
        CMD_LOAD: begin
          ctrl.load  = 1'b1;
          ctrl.clear = 1'b1;
        end
        CMD_WORD: ctrl.step = 1'b1;
        CMD_EOS: begin
          ctrl.clear = 1'b1;
          push       = 1'b1;
        end
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < MAX_QUERY; i++) begin : g_cell
    logic prev;
    if (i == 0) begin : g_head
      assign prev = 1'b1;
    end else begin : g_link
      assign prev = match_q[i-1];
    end
    wsm_cell #(
      .IDX  (i),
      .ID_W (IdW)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .slot_i       (slot),
      .word_i       (word),
      .match_prev_i (prev),
      .match_q_o    (match_q[i]),
      .match_d_o    (match_d[i])
    );
  end

  // Sticky hit: tap the cell at the query's last position
  always_comb begin
    hit_d = hit_q;
    if (ctrl.clear) begin
      hit_d = 1'b0;
    end else if (ctrl.step && len_eff != '0 && match_d[tap_idx]) begin
      hit_d = 1'b1;
    end
  end

  always_comb begin
    sentence_cnt_d = sentence_cnt_q;
    if (ctrl.load) begin
      sentence_cnt_d = '0;
    end else if (push) begin
      sentence_cnt_d = sentence_cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q          <= 1'b0;
      sentence_cnt_q <= '0;
    end else begin
      hit_q          <= hit_d;
      sentence_cnt_q <= sentence_cnt_d;
    end
  end

  assign result.found           = hit_q || (len_eff == '0);
  assign result.sentence_number = sentence_cnt_q;

  wsm_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (result),
    .ready_o (s_axis_tready_o),
    .valid_o (m_axis_tvalid_o),
    .data_o  (head),
    .ready_i (m_axis_tready_i)
  );

  assign m_axis_tdata_o = {{(OUT_TDATA_W - CNT_W - 1){1'b0}}, head.sentence_number, head.found};

  a_eos_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_accept && cmd == CMD_EOS) |=> m_axis_tvalid_o)
    else $error("end of sentence accepted but no result pending");

  a_load_restarts_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_accept && cmd == CMD_LOAD) |=> (sentence_cnt_q == '0 && !hit_q))
    else $error("query load did not restart sentence numbering");

  a_eos_clears_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_accept && cmd == CMD_EOS) |=> (!hit_q && !match_q[0]))
    else $error("window not cleared after end of sentence");

endmodule
